@@ hdl/tts_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// Tick task scheduler package
// Operation codes, result status codes, sequencer states and default sizes.
// ---------------------------------------------------------------------------
package tts_pkg;

  localparam int DefNumSlots  = 8;
  localparam int DefCountBits = 16;

  localparam int OpW     = 2;
  localparam int SlotFw  = 3;
  localparam int FieldW  = 16;
  localparam int StatusW = 2;

  typedef enum logic [OpW-1:0] {
    OP_TICK   = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_RUN    = 2'd3
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_DONE       = 2'd0,
    ST_REJECTED   = 2'd1,
    ST_TASK_READY = 2'd2,
    ST_NONE_READY = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_EXEC = 3'b100
  } state_e;

endpackage : tts_pkg
`default_nettype wire

@@ hdl/tts_slot_mem.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// Slot entry memory
// One write port and one read port with registered read data; holds the
// period and countdown of every slot.
// ---------------------------------------------------------------------------
module tts_slot_mem #(
  parameter int Depth = 8,
  parameter int Width = 32,
  parameter int AddrW = 3
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule : tts_slot_mem
`default_nettype wire

@@ hdl/tts_count_unit.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// Countdown unit
// Shared by every slot in turn: decrements a count that is above zero and
// reloads it from a nonzero period when it expires.
// ---------------------------------------------------------------------------
module tts_count_unit #(
  parameter int CountBits = 16
) (
  input  wire logic [CountBits-1:0] count_i,
  input  wire logic [CountBits-1:0] period_i,
  output logic      [CountBits-1:0] next_count_o,
  output logic                      expired_o
);

  logic [CountBits-1:0] dec;

  assign dec          = (count_i != '0) ? count_i - 1'b1 : '0;
  assign expired_o    = (dec == '0);
  assign next_count_o = (expired_o && (period_i != '0)) ? period_i : dec;

endmodule : tts_count_unit
`default_nettype wire

@@ hdl/tick_task_scheduler.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// Tick task scheduler
// Software-timer style task table with slot ids in place of callbacks.
// ---------------------------------------------------------------------------
// Add and remove finish in the cycle they are accepted: the result beat
// appears in the next cycle and busy_o never rises, so another command can
// follow immediately. Tick and run walk the slot table through one
// memory read port and one countdown unit, taking each slot through a
// read state and then an execute state while busy_o stays high. A run
// delivers one beat per ready slot, or a none-ready beat if none is ready;
// the final beat of any command carries last_o. Results are shown for
// exactly one cycle on result_valid_o and cannot be held off by the receiver.
module tick_task_scheduler
  import tts_pkg::*;
#(
  parameter int NUM_SLOTS  = DefNumSlots,
  parameter int COUNT_BITS = DefCountBits
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire logic [OpW-1:0]     op_i,
  input  wire logic [SlotFw-1:0]  slot_i,
  input  wire logic [FieldW-1:0]  initial_delay_i,
  input  wire logic [FieldW-1:0]  reload_period_i,
  output logic                    result_valid_o,
  output logic [StatusW-1:0]      status_o,
  output logic [SlotFw-1:0]       task_slot_o,
  output logic                    last_o
);

  localparam int SlotW  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int EntryW = 2 * COUNT_BITS;

  state_e                state_q, state_d;
  op_e                   op_q, op_d;
  logic [SlotFw-1:0]     slot_q, slot_d;
  logic [SlotW-1:0]      idx_q, idx_d;
  logic                  found_q, found_d;
  logic [NUM_SLOTS-1:0]  valid_q, valid_d;
  logic [NUM_SLOTS-1:0]  ready_q, ready_d;
  logic                  out_valid_q, out_valid_d;
  status_e               status_q, status_d;
  logic [SlotFw-1:0]     tslot_q, tslot_d;
  logic                  last_q, last_d;

  logic                  accept;
  logic                  slot_ok;
  logic [SlotW-1:0]      slot_idx;
  logic                  is_end;
  logic                  later_any;

  logic                  mem_we;
  logic [SlotW-1:0]      mem_waddr;
  logic [EntryW-1:0]     mem_wdata;
  logic                  mem_re;
  logic [EntryW-1:0]     mem_rdata;

  logic [COUNT_BITS-1:0] cur_count;
  logic [COUNT_BITS-1:0] cur_period;
  logic [COUNT_BITS-1:0] next_count;
  logic                  expired;

  assign busy_o   = (state_q != S_IDLE);
  assign accept   = start_i && !busy_o;
  assign slot_ok  = (32'(slot_i) < NUM_SLOTS);
  assign slot_idx = SlotW'(slot_i);
  assign is_end   = (idx_q == SlotW'(NUM_SLOTS - 1));

  assign cur_count  = mem_rdata[COUNT_BITS-1:0];
  assign cur_period = mem_rdata[EntryW-1:COUNT_BITS];

  tts_slot_mem #(
    .Depth(NUM_SLOTS),
    .Width(EntryW),
    .AddrW(SlotW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(idx_q),
    .rdata_o(mem_rdata)
  );

  tts_count_unit #(
    .CountBits(COUNT_BITS)
  ) u_count (
    .count_i     (cur_count),
    .period_i    (cur_period),
    .next_count_o(next_count),
    .expired_o   (expired)
  );

  // Tells whether any slot above the current one is still due in this run.
  always_comb begin
    later_any = 1'b0;
    for (int j = 0; j < NUM_SLOTS; j++) begin
      if ((j > int'(idx_q)) && valid_q[j] && ready_q[j]) begin
        later_any = 1'b1;
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    slot_d      = slot_q;
    idx_d       = idx_q;
    found_d     = found_q;
    valid_d     = valid_q;
    ready_d     = ready_q;
    out_valid_d = 1'b0;
    status_d    = status_q;
    tslot_d     = tslot_q;
    last_d      = last_q;
    mem_we      = 1'b0;
    mem_waddr   = idx_q;
    mem_wdata   = {cur_period, next_count};
    mem_re      = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d    = op_e'(op_i);
          slot_d  = slot_i;
          idx_d   = '0;
          found_d = 1'b0;
          case (op_e'(op_i))
            OP_ADD: begin
              out_valid_d = 1'b1;
              tslot_d     = slot_i;
              last_d      = 1'b1;
              if (slot_ok && !valid_q[slot_idx]) begin
                status_d          = ST_DONE;
                valid_d[slot_idx] = 1'b1;
                ready_d[slot_idx] = 1'b0;
                mem_we            = 1'b1;
                mem_waddr         = slot_idx;
                mem_wdata         = {COUNT_BITS'(reload_period_i),
                                     COUNT_BITS'(initial_delay_i)};
              end else begin
                status_d = ST_REJECTED;
              end
            end
            OP_REMOVE: begin
              out_valid_d = 1'b1;
              status_d    = ST_DONE;
              tslot_d     = slot_i;
              last_d      = 1'b1;
              if (slot_ok) begin
                valid_d[slot_idx] = 1'b0;
                ready_d[slot_idx] = 1'b0;
              end
            end
            default: begin
              state_d = S_READ;
            end
          endcase
        end
      end
      S_READ: begin
        mem_re  = 1'b1;
        state_d = S_EXEC;
      end
      S_EXEC: begin
        if (op_q == OP_TICK) begin
          if (valid_q[idx_q]) begin
            mem_we = 1'b1;
            if (expired) begin
              ready_d[idx_q] = 1'b1;
            end
          end
          if (is_end) begin
            out_valid_d = 1'b1;
            status_d    = ST_DONE;
            tslot_d     = slot_q;
            last_d      = 1'b1;
          end
        end else begin
          if (valid_q[idx_q] && ready_q[idx_q]) begin
            out_valid_d    = 1'b1;
            status_d       = ST_TASK_READY;
            tslot_d        = SlotFw'(idx_q);
            last_d         = !later_any;
            found_d        = 1'b1;
            ready_d[idx_q] = 1'b0;
            // One-shot tasks leave the table once they have run.
            if (cur_period == '0) begin
              valid_d[idx_q] = 1'b0;
            end
          end else if (is_end && !found_q) begin
            out_valid_d = 1'b1;
            status_d    = ST_NONE_READY;
            tslot_d     = slot_q;
            last_d      = 1'b1;
          end
        end
        if (is_end) begin
          state_d = S_IDLE;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_READ;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      ready_q     <= '0;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      ready_q     <= ready_d;
      out_valid_q <= out_valid_d;
      found_q     <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    slot_q   <= slot_d;
    idx_q    <= idx_d;
    status_q <= status_d;
    tslot_q  <= tslot_d;
    last_q   <= last_d;
  end

  assign result_valid_o = out_valid_q;
  assign status_o       = status_q;
  assign task_slot_o    = tslot_q;
  assign last_o         = last_q;

endmodule : tick_task_scheduler
`default_nettype wire

@@ hdl/tts_checker.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// Tick task scheduler port checker
// Watches the command and result ports over time; bound to the top level.
// ---------------------------------------------------------------------------
module tts_checker
  import tts_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               start_i,
  input wire logic               busy_o,
  input wire logic [OpW-1:0]     op_i,
  input wire logic [SlotFw-1:0]  slot_i,
  input wire logic               result_valid_o,
  input wire logic [StatusW-1:0] status_o,
  input wire logic [SlotFw-1:0]  task_slot_o,
  input wire logic               last_o
);

  logic accept;
  logic table_cmd;

  assign accept    = start_i && !busy_o;
  assign table_cmd = (op_i == OP_ADD) || (op_i == OP_REMOVE);

  // Add and remove answer with a single final beat in the next cycle.
  a_table_cmd_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && table_cmd |=> result_valid_o && last_o &&
      ((status_o == ST_DONE) || (status_o == ST_REJECTED)) &&
      (task_slot_o == $past(slot_i)))
    else $error("add or remove did not answer in the next cycle");

  // Tick and run occupy the block after they are taken.
  a_walk_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !table_cmd |=> busy_o)
    else $error("tick or run did not hold busy");

  // Only a ready task beat may be followed by more beats of the same command.
  a_single_beats_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (status_o != ST_TASK_READY) |-> last_o)
    else $error("non-task result without last");

  // A single-beat answer comes once the walk is over, so the block is free.
  // A run may still be walking the upper slots when its final task beat shows.
  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_o && (status_o != ST_TASK_READY) |-> !busy_o)
    else $error("busy still high at final beat");

endmodule : tts_checker

bind tick_task_scheduler tts_checker u_tts_checker (.*);
`default_nettype wire
